// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the vector unit rtl
// included by the modules that check their own control logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// expression never true outside reset
`define ASSERT_NEVER(name, clk, rst_n, expr, msg) \
    `ASSERT_CLK(name, clk, rst_n, !(expr), msg)

`endif

// ===== rtl/core/vula_pkg.sv =====
// types, sizes and codes of the vector load/store/add unit
// no dependencies; imported by every module of the block
`default_nettype none

package vula_pkg;

    localparam int NUM_VREGS      = 32;
    localparam int VREG_BYTES     = 64;
    localparam int UB_BYTES       = 4096;
    localparam int WORD_BYTES     = 4;

    localparam int WORDS_PER_VREG = VREG_BYTES / WORD_BYTES;
    localparam int VREG_IW        = (NUM_VREGS > 1) ? $clog2(NUM_VREGS) : 1;
    localparam int VWORD_IW       = (WORDS_PER_VREG > 1) ? $clog2(WORDS_PER_VREG) : 1;
    localparam int BYTE_IW        = VWORD_IW + 2;
    localparam int VRF_AW         = VREG_IW + VWORD_IW;
    localparam int VRF_DEPTH      = 2 ** VRF_AW;
    localparam int UB_AW          = $clog2(UB_BYTES);
    localparam int CNT_W          = VRF_AW + 2;
    localparam int NB_W           = $clog2(VREG_BYTES + 1);

    localparam int FUNC_W         = 3;
    localparam int REG_W          = 8;
    localparam int ADDR_W         = 16;
    localparam int LEN_W          = 16;
    localparam int EB_W           = 8;
    localparam int BYTE_W         = 8;
    localparam int STATUS_W       = 3;
    localparam int NBYTES_W       = LEN_W + EB_W;
    localparam int CFG_W          = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam int S_TDATA_W      = 80;
    localparam int M_TDATA_W      = 16;

    typedef enum logic [FUNC_W-1:0] {
        FN_VLOAD  = 3'd0,
        FN_VSTORE = 3'd1,
        FN_VADD   = 3'd2,
        FN_HWRITE = 3'd3,
        FN_HREAD  = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_LEN   = 3'd1,
        ST_EEW   = 3'd2,
        ST_REG   = 3'd3,
        ST_UNSUP = 3'd4,
        ST_RANGE = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_LOAD,
        S_STORE,
        S_ADD,
        S_HOST,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_CAPTURE,
        DP_MUL,
        DP_CHECK,
        DP_CLEAR,
        DP_LOAD,
        DP_STORE,
        DP_ADD,
        DP_HOST,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        logic  loop_done;
        logic  check_ok;
        t_func func;
        logic  out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/core/vector_unit_load_store_add.sv =====
// vector unit: 32 x 64-byte register file, 4 KiB unified buffer; vload,
// vstore, vadd and host byte access. One command beat in, one status beat out.
// Command beat on s_axis (tdata fields below); result beat on m_axis.
// i_cfg_wr_en/i_cfg_wr_data set the usable bytes per register (reset 64);
// write it only while no command is in flight.
// After reset the register file is swept to zero, one word per cycle:
// 512 words, with s_axis_tready held low until the sweep ends.
// Sequencer steps from command accept to result loaded: accept, multiply,
// check, loop, result. A failed check goes straight to the result; a host
// write/read runs one host step in place of the loop. Per loop:
//   vload: one buffer byte a cycle over all 64 register bytes, padding too
//   vstore: n bytes, n the byte count (one buffer write port, one byte a cycle)
//   vadd: n / 4 words (one 32-bit word a cycle through the two read ports)
// One command at a time: the next one is taken when the previous result sits
// in the output register, so a stalled m_axis holds only the next command
// at the point its result is ready.
// depends on vula_pkg, vula_ctrl, vula_dp
`default_nettype none

module vector_unit_load_store_add
    import vula_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // func[2:0] dst_reg[10:3] src_reg_a[18:11] src_reg_b[26:19] ub_addr[42:27]
    // vec_len[58:43] elem_bytes[66:59] host_byte[74:67], zero above
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // status[2:0] read_byte[10:3], zero above
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_W-1:0]     i_cfg_wr_data
);

    t_dp_op  w_op;
    t_dp_sts w_sts;

    vula_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (w_sts),
        .o_op    (w_op)
    );

    vula_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (w_op),
        .o_sts         (w_sts),
        .i_s_tdata     (s_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_m_tready    (m_axis_tready),
        .o_m_tvalid    (m_axis_tvalid),
        .o_m_tdata     (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/core/vula_ctrl.sv =====
// sequencer of the vector unit: reset clear, checks, copy/add loops, result
// depends on vula_pkg and assert_macros.svh; drives vula_dp by op codes
`default_nettype none
`include "assert_macros.svh"

module vula_ctrl
    import vula_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_op       o_op
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.loop_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!i_sts.check_ok) begin
                    n_state = S_DONE;
                end else begin
                    unique case (i_sts.func)
                        FN_VLOAD:  n_state = S_LOAD;
                        FN_VSTORE: n_state = S_STORE;
                        FN_VADD:   n_state = S_ADD;
                        default:   n_state = S_HOST;
                    endcase
                end
            end
            S_LOAD, S_STORE, S_ADD: begin
                if (i_sts.loop_done) n_state = S_DONE;
            end
            S_HOST: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_op    = DP_NONE;
        unique case (r_state)
            S_CLEAR: o_op = DP_CLEAR;
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) o_op = DP_CAPTURE;
            end
            S_MUL:   o_op = DP_MUL;
            S_CHECK: o_op = DP_CHECK;
            S_LOAD:  o_op = DP_LOAD;
            S_STORE: o_op = DP_STORE;
            S_ADD:   o_op = DP_ADD;
            S_HOST:  o_op = DP_HOST;
            S_DONE: begin
                if (i_sts.out_free) o_op = DP_OUT;
            end
            default: o_op = DP_NONE;
        endcase
    end

    `ASSERT_CLK(a_fail_to_done, i_clk, i_rst_n, (r_state == S_CHECK && !i_sts.check_ok) |=> (r_state == S_DONE), "failed check did not go straight to result")
    `ASSERT_CLK(a_out_when_free, i_clk, i_rst_n, (o_op == DP_OUT) |-> i_sts.out_free, "result issued into a full output register")
    `ASSERT_CLK(a_loop_exit, i_clk, i_rst_n, ((r_state == S_LOAD || r_state == S_STORE || r_state == S_ADD) && i_sts.loop_done) |=> (r_state == S_DONE), "loop end not followed by result")

endmodule

`default_nettype wire

// ===== rtl/core/vula_dp.sv =====
// datapath of the vector unit: command registers, checks, register file,
// unified buffer, loop counter and output register; depends on vula_pkg
`default_nettype none
`include "assert_macros.svh"

module vula_dp
    import vula_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_op               i_op,
    output t_dp_sts                   o_sts,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_W-1:0]     i_cfg_wr_data,
    input  wire logic                 i_m_tready,
    output logic                      o_m_tvalid,
    output logic [M_TDATA_W-1:0]      o_m_tdata
);

    // command fields
    t_func               r_func;
    logic [REG_W-1:0]    r_dst;
    logic [REG_W-1:0]    r_sa;
    logic [REG_W-1:0]    r_sb;
    logic [ADDR_W-1:0]   r_addr;
    logic [LEN_W-1:0]    r_len;
    logic [EB_W-1:0]     r_eb;
    logic [BYTE_W-1:0]   r_hb;
    logic [NBYTES_W-1:0] r_nbytes;
    t_status             r_status;
    logic [CFG_W-1:0]    r_cfg;

    // loop counter and one pipeline stage behind the memory reads
    logic [CNT_W-1:0]    r_cnt;
    logic                r_p_vld;
    logic [VRF_AW-1:0]   r_p_waddr;
    logic [1:0]          r_p_lane;
    logic                r_p_zero;
    logic [UB_AW-1:0]    r_p_ubaddr;

    // output register
    logic                r_o_vld;
    t_status             r_o_status;
    logic [BYTE_W-1:0]   r_o_byte;

    // memories
    logic [BYTE_W-1:0]   ub_mem [0:UB_BYTES-1];
    logic [31:0]         vrf_mem [0:VRF_DEPTH-1];
    logic [BYTE_W-1:0]   r_ub_rdata;
    logic [31:0]         r_rd_a;
    logic [31:0]         r_rd_b;

    logic                w_ub_we;
    logic [UB_AW-1:0]    w_ub_waddr;
    logic [BYTE_W-1:0]   w_ub_wdata;
    logic                w_ub_re;
    logic [UB_AW-1:0]    w_ub_raddr;
    logic                w_vrf_we;
    logic [VRF_AW-1:0]   w_vrf_waddr;
    logic [3:0]          w_vrf_be;
    logic [31:0]         w_vrf_wdata;
    logic                w_vrf_re;
    logic [VRF_AW-1:0]   w_vrf_raddr_a;
    logic [VRF_AW-1:0]   w_vrf_raddr_b;

    logic [CNT_W-1:0]    w_limit;
    logic                w_cnt_lt;
    logic                w_issue;
    logic [VRF_AW-1:0]   w_iss_waddr;
    logic                w_iss_zero;
    logic [UB_AW-1:0]    w_iss_ubaddr;
    logic [BYTE_IW-1:0]  w_byte;
    logic [NB_W-1:0]     w_n;
    logic [BYTE_W-1:0]   w_ld_byte;

    logic [NBYTES_W-1:0] w_usable;
    logic                w_len_bad;
    logic                w_range_bad;
    logic                w_host_bad;
    logic                w_dst_ok;
    logic                w_sa_ok;
    logic                w_sb_ok;
    t_status             w_status;

    // checks
    always_comb begin
        w_usable = ({{(NBYTES_W-CFG_W){1'b0}}, r_cfg} > NBYTES_W'(VREG_BYTES))
                 ? NBYTES_W'(VREG_BYTES) : {{(NBYTES_W-CFG_W){1'b0}}, r_cfg};
        w_len_bad   = (r_nbytes == '0) || (r_nbytes > w_usable);
        w_range_bad = ((NBYTES_W+1)'(r_addr) + (NBYTES_W+1)'(r_nbytes))
                      > (NBYTES_W+1)'(UB_BYTES);
        w_host_bad  = ((ADDR_W+1)'(r_addr)) >= (ADDR_W+1)'(UB_BYTES);
        w_dst_ok    = ((REG_W+1)'(r_dst)) < (REG_W+1)'(NUM_VREGS);
        w_sa_ok     = ((REG_W+1)'(r_sa)) < (REG_W+1)'(NUM_VREGS);
        w_sb_ok     = ((REG_W+1)'(r_sb)) < (REG_W+1)'(NUM_VREGS);
        w_status    = ST_OK;
        unique case (r_func)
            FN_VLOAD: begin
                priority if (w_len_bad) w_status = ST_LEN;
                else if (!w_dst_ok)     w_status = ST_REG;
                else if (w_range_bad)   w_status = ST_RANGE;
                else                    w_status = ST_OK;
            end
            FN_VSTORE: begin
                priority if (w_len_bad) w_status = ST_LEN;
                else if (!w_sb_ok)      w_status = ST_REG;
                else if (w_range_bad)   w_status = ST_RANGE;
                else                    w_status = ST_OK;
            end
            FN_VADD: begin
                priority if (r_eb != EB_W'(WORD_BYTES))   w_status = ST_EEW;
                else if (w_len_bad)                       w_status = ST_LEN;
                else if (!w_dst_ok || !w_sa_ok || !w_sb_ok) w_status = ST_REG;
                else                                      w_status = ST_OK;
            end
            FN_HWRITE, FN_HREAD: begin
                w_status = w_host_bad ? ST_RANGE : ST_OK;
            end
            default: w_status = ST_UNSUP;
        endcase
    end

    // loop issue side
    always_comb begin
        w_n      = r_nbytes[NB_W-1:0];
        w_byte   = r_cnt[BYTE_IW-1:0];
        unique case (i_op)
            DP_CLEAR: w_limit = CNT_W'(VRF_DEPTH);
            DP_LOAD:  w_limit = CNT_W'(VREG_BYTES);
            DP_STORE: w_limit = CNT_W'(w_n);
            DP_ADD:   w_limit = CNT_W'(w_n[NB_W-1:2]);
            default:  w_limit = '0;
        endcase
        w_cnt_lt = r_cnt < w_limit;
        w_issue  = w_cnt_lt && (i_op == DP_LOAD || i_op == DP_STORE || i_op == DP_ADD);

        w_ub_re       = 1'b0;
        w_ub_raddr    = r_addr[UB_AW-1:0] + UB_AW'(r_cnt);
        w_vrf_re      = 1'b0;
        w_vrf_raddr_a = {r_sa[VREG_IW-1:0], r_cnt[VWORD_IW-1:0]};
        w_vrf_raddr_b = {r_sb[VREG_IW-1:0], r_cnt[VWORD_IW-1:0]};
        w_iss_waddr   = {r_dst[VREG_IW-1:0], r_cnt[VWORD_IW-1:0]};
        w_iss_zero    = 1'b0;
        w_iss_ubaddr  = r_addr[UB_AW-1:0] + UB_AW'(r_cnt);

        unique case (i_op)
            DP_LOAD: begin
                w_iss_waddr = {r_dst[VREG_IW-1:0], w_byte[BYTE_IW-1:2]};
                w_iss_zero  = r_cnt >= CNT_W'(w_n);
                w_ub_re     = w_issue && !w_iss_zero;
            end
            DP_STORE: begin
                w_vrf_raddr_b = {r_sb[VREG_IW-1:0], w_byte[BYTE_IW-1:2]};
                w_vrf_re      = w_issue;
            end
            DP_ADD: begin
                w_vrf_re = w_issue;
            end
            DP_HOST: begin
                w_ub_raddr = r_addr[UB_AW-1:0];
                w_ub_re    = (r_func == FN_HREAD);
            end
            default: begin
                w_vrf_re = 1'b0;
            end
        endcase
    end

    // write side: clear sweep, host write, and the stage after the reads
    always_comb begin
        w_ld_byte   = r_p_zero ? '0 : r_ub_rdata;
        w_ub_we     = 1'b0;
        w_ub_waddr  = r_p_ubaddr;
        w_ub_wdata  = r_rd_b[8*r_p_lane +: 8];
        w_vrf_we    = 1'b0;
        w_vrf_waddr = r_p_waddr;
        w_vrf_be    = 4'b1111;
        w_vrf_wdata = r_rd_a + r_rd_b;
        unique case (i_op)
            DP_CLEAR: begin
                w_vrf_we    = w_cnt_lt;
                w_vrf_waddr = r_cnt[VRF_AW-1:0];
                w_vrf_wdata = '0;
            end
            DP_LOAD: begin
                w_vrf_we    = r_p_vld;
                w_vrf_be    = 4'b0001 << r_p_lane;
                w_vrf_wdata = {4{w_ld_byte}};
            end
            DP_STORE: begin
                w_ub_we = r_p_vld;
            end
            DP_ADD: begin
                w_vrf_we = r_p_vld;
            end
            DP_HOST: begin
                w_ub_we    = (r_func == FN_HWRITE);
                w_ub_waddr = r_addr[UB_AW-1:0];
                w_ub_wdata = r_hb;
            end
            default: begin
                w_ub_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ub_we) ub_mem[w_ub_waddr] <= w_ub_wdata;
        if (w_ub_re) r_ub_rdata <= ub_mem[w_ub_raddr];
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 4; l++) begin
            if (w_vrf_we && w_vrf_be[l]) vrf_mem[w_vrf_waddr][8*l +: 8] <= w_vrf_wdata[8*l +: 8];
        end
        if (w_vrf_re) begin
            r_rd_a <= vrf_mem[w_vrf_raddr_a];
            r_rd_b <= vrf_mem[w_vrf_raddr_b];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= CFG_RESET;
            r_cnt   <= '0;
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_cfg <= i_cfg_wr_data;
            if (i_op == DP_CAPTURE) begin
                r_cnt <= '0;
            end else if (w_cnt_lt) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_p_vld <= w_issue;
            if (i_op == DP_OUT) begin
                r_o_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_op == DP_CAPTURE) begin
            r_func <= t_func'(i_s_tdata[2:0]);
            r_dst  <= i_s_tdata[10:3];
            r_sa   <= i_s_tdata[18:11];
            r_sb   <= i_s_tdata[26:19];
            r_addr <= i_s_tdata[42:27];
            r_len  <= i_s_tdata[58:43];
            r_eb   <= i_s_tdata[66:59];
            r_hb   <= i_s_tdata[74:67];
        end
        if (i_op == DP_MUL) r_nbytes <= r_len * r_eb;
        if (i_op == DP_CHECK) r_status <= w_status;
        if (w_issue) begin
            r_p_waddr  <= w_iss_waddr;
            r_p_lane   <= w_byte[1:0];
            r_p_zero   <= w_iss_zero;
            r_p_ubaddr <= w_iss_ubaddr;
        end
        if (i_op == DP_OUT) begin
            r_o_status <= r_status;
            r_o_byte   <= (r_func == FN_HREAD && r_status == ST_OK) ? r_ub_rdata : '0;
        end
    end

    assign o_sts.loop_done = !w_cnt_lt && !r_p_vld;
    assign o_sts.check_ok  = (w_status == ST_OK);
    assign o_sts.func      = r_func;
    assign o_sts.out_free  = !r_o_vld || i_m_tready;

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = {{(M_TDATA_W-STATUS_W-BYTE_W){1'b0}}, r_o_byte, r_o_status};

    `ASSERT_CLK(a_load_cnt_bound, i_clk, i_rst_n, (i_op == DP_LOAD) |-> (r_cnt <= CNT_W'(VREG_BYTES)), "load counter ran past the register size")
    `ASSERT_CLK(a_byte_only_ok, i_clk, i_rst_n, r_o_vld |-> (r_o_byte == '0 || r_o_status == ST_OK), "read byte returned with an error status")
    `ASSERT_NEVER(a_out_overrun, i_clk, i_rst_n, (i_op == DP_OUT) && r_o_vld && !i_m_tready, "output register overwritten before it was taken")

endmodule

`default_nettype wire
